[rtl/core/header_length_sum_block_deframer_macros.svh]
// Assertion macros for the deframer.
`ifndef HEADER_LENGTH_SUM_BLOCK_DEFRAMER_MACROS_SVH
`define HEADER_LENGTH_SUM_BLOCK_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define HLSBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HLSBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLSBD_ASSERT(lbl, clk, rst, prop, msg)
`define HLSBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/hlsbd_pkg.sv]
package hlsbd_pkg;

  localparam int DEF_BLOCK_BYTES = 10;
  localparam int DEF_MAX_BLOCKS  = 64;
  localparam int DEF_MAX_PAYLOAD = 640;

  localparam int NUM_LANES  = 10;
  localparam int LANE_W     = 4;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int MIN_W      = 10;
  localparam int CNT_W      = MIN_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES  = 2'd2;

  localparam logic [MIN_W-1:0] MIN_BYTES_RESET = 10'd15;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_READ0 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN = STEP_READ0 + STEP_W'(NUM_LANES);
  localparam logic [STEP_W-1:0] STEP_SHOW  = STEP_DRAIN + 4'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] block_id;
    logic [63:0] block_payload;
    logic        block_last;
  } out_item_t;

  typedef enum logic [6:0] {
    PH_HEAD1   = 7'b0000001,
    PH_HEAD2   = 7'b0000010,
    PH_LEN_LO  = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CHECK   = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_IDLE,
    J_OUT
  } jump_t;

  typedef struct packed {
    logic              take_in;
    logic              rd_en;
    logic [LANE_W-1:0] rd_off;
    logic              cap_en;
    logic [LANE_W-1:0] cap_lane;
    logic              show;
    jump_t             jmp;
  } ctrl_word_t;

  // Control store: the idle step parses bytes, the read steps walk one block of
  // the payload store, the drain step takes the last read and the show step
  // holds the block until its transfer.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w.take_in  = 1'b0;
    w.rd_en    = 1'b0;
    w.rd_off   = '0;
    w.cap_en   = 1'b0;
    w.cap_lane = '0;
    w.show     = 1'b0;
    w.jmp      = J_NEXT;
    if (step inside {[STEP_READ0:STEP_DRAIN - 4'd1]}) begin
      w.rd_en  = 1'b1;
      w.rd_off = step - STEP_READ0;
    end
    if (step inside {[STEP_READ0 + 4'd1:STEP_DRAIN]}) begin
      w.cap_en   = 1'b1;
      w.cap_lane = step - STEP_READ0 - 4'd1;
    end
    case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.jmp     = J_IDLE;
      end
      STEP_SHOW: begin
        w.show = 1'b1;
        w.jmp  = J_OUT;
      end
      default: begin
        if (step > STEP_SHOW) begin
          w.jmp = J_IDLE;
        end
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/header_length_sum_block_deframer.sv]
// After the last byte of a buffer with a good frame, the block sequencer walks
// the read steps, one payload store read per block byte, and the drain step
// before the first block can transfer; each further block repeats these steps
// after the previous transfer. No byte is taken meanwhile.
// Reset: rst, synchronous, clears the parser, sequencer and registers to their
// defaults; the payload store is not cleared and needs no clearing pass.
`include "header_length_sum_block_deframer_macros.svh"

module header_length_sum_block_deframer #(
  parameter int BLOCK_BYTES = hlsbd_pkg::DEF_BLOCK_BYTES,
  parameter int MAX_BLOCKS  = hlsbd_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAYLOAD = hlsbd_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hlsbd_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hlsbd_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [hlsbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hlsbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hlsbd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PAYLOAD);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int SUM_W  = LEN_W + 2;
  localparam int KW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [7:0]       hdr_first;
  logic [7:0]       hdr_second;
  logic [MIN_W-1:0] min_bytes;

  phase_t           phase, phase_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] pos, pos_next;
  logic [7:0]       sum, sum_next;
  logic             pending, pending_next;
  logic [CNT_W-1:0] cnt, cnt_inc;

  logic [STEP_W-1:0] step, step_next;
  logic [LEN_W-1:0]  base;
  logic [KW-1:0]     blk;
  logic [7:0]        rd_data;
  logic              rd_zero;
  logic [7:0]        lane [NUM_LANES];
  logic [7:0]        store [MAX_PAYLOAD];

  ctrl_word_t  ctrl;
  logic        in_fire, out_fire, emit_go, last, rd_hit, pending_now;
  logic [15:0] len_full;
  logic [SUM_W-1:0] rd_pos, blk_end2;

  assign ctrl      = ucode(step);
  assign in_ready  = ctrl.take_in;
  assign out_valid = ctrl.show;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign len_full    = {in_data.rx_byte, len_lo};
  assign cnt_inc     = (cnt == '1) ? cnt : cnt + 1'b1;
  assign pending_now = (phase == PH_CHECK) ? (in_data.rx_byte == sum) : pending;
  assign emit_go     = in_fire && in_data.buffer_end && pending_now
                       && ({1'b0, min_bytes} <= cnt_inc)
                       && (SUM_W'(len) >= SUM_W'(BLOCK_BYTES));

  assign rd_pos   = SUM_W'(base) + SUM_W'(ctrl.rd_off);
  assign rd_hit   = rd_pos < SUM_W'(len);
  assign blk_end2 = SUM_W'(base) + SUM_W'(2 * BLOCK_BYTES);
  assign last     = (blk_end2 > SUM_W'(len)) || (blk == KW'(MAX_BLOCKS - 1));

  assign out_data.block_id      = {lane[1], lane[0]};
  assign out_data.block_payload = {lane[9], lane[8], lane[7], lane[6],
                                   lane[5], lane[4], lane[3], lane[2]};
  assign out_data.block_last    = last;

  always_comb begin
    phase_next   = phase;
    len_lo_next  = len_lo;
    len_next     = len;
    pos_next     = pos;
    sum_next     = sum;
    pending_next = pending_now;
    case (phase)
      PH_HEAD1: begin
        phase_next = (in_data.rx_byte == hdr_first) ? PH_HEAD2 : PH_SKIP;
      end
      PH_HEAD2: begin
        phase_next = (in_data.rx_byte == hdr_second) ? PH_LEN_LO : PH_SKIP;
      end
      PH_LEN_LO: begin
        len_lo_next = in_data.rx_byte;
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_next = LEN_W'(len_full);
        pos_next = '0;
        sum_next = '0;
        if (len_full > 16'(MAX_PAYLOAD)) begin
          phase_next = PH_SKIP;
        end else if (len_full == 16'd0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_next = sum + in_data.rx_byte;
        pos_next = pos + 1'b1;
        if (pos + 1'b1 >= len) begin
          phase_next = PH_CHECK;
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase
    if (in_data.buffer_end) begin
      phase_next   = PH_HEAD1;
      pending_next = 1'b0;
    end
  end

  always_comb begin
    case (ctrl.jmp)
      J_NEXT: begin
        step_next = step + 1'b1;
      end
      J_IDLE: begin
        step_next = emit_go ? STEP_READ0 : STEP_IDLE;
      end
      J_OUT: begin
        if (out_fire) begin
          step_next = last ? STEP_IDLE : STEP_READ0;
        end else begin
          step_next = step;
        end
      end
      default: begin
        step_next = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= '0;
      hdr_second <= '0;
      min_bytes  <= MIN_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HDR_FIRST:  hdr_first  <= cfg_wdata[7:0];
        REG_HDR_SECOND: hdr_second <= cfg_wdata[7:0];
        REG_MIN_BYTES:  min_bytes  <= cfg_wdata[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEAD1;
      len_lo  <= '0;
      len     <= '0;
      pos     <= '0;
      sum     <= '0;
      pending <= 1'b0;
      cnt     <= '0;
    end else if (in_fire) begin
      phase   <= phase_next;
      len_lo  <= len_lo_next;
      len     <= len_next;
      pos     <= pos_next;
      sum     <= sum_next;
      pending <= pending_next;
      cnt     <= in_data.buffer_end ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_IDLE;
      base    <= '0;
      blk     <= '0;
      rd_zero <= 1'b0;
    end else begin
      step <= step_next;
      if (emit_go) begin
        base <= '0;
        blk  <= '0;
      end else if (out_fire && !last) begin
        base <= base + LEN_W'(BLOCK_BYTES);
        blk  <= blk + 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_zero <= !rd_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (phase == PH_PAYLOAD)) begin
      store[pos[ADDR_W-1:0]] <= in_data.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en && rd_hit) begin
      rd_data <= store[rd_pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_en) begin
      lane[ctrl.cap_lane] <= rd_zero ? 8'd0 : rd_data;
    end
  end

  `HLSBD_ASSERT(a_sides_apart, clk, rst, !(in_ready && out_valid), "input taken during emission")
  `HLSBD_ASSERT(a_next_block, clk, rst, (out_fire && !last) |=> (step == STEP_READ0), "block walk lost")
  `HLSBD_ASSERT(a_frame_done, clk, rst, (out_fire && last) |=> in_ready, "no return to parsing")
  `HLSBD_ASSERT(a_block_fits, clk, rst, out_valid |-> (SUM_W'(base) + SUM_W'(BLOCK_BYTES) <= SUM_W'(len)), "block beyond payload")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import hlsbd_pkg::*;

  localparam int BLK_BYTES = DEF_BLOCK_BYTES;
  localparam int MAX_BLK = DEF_MAX_BLOCKS;
  localparam int MAX_PAY = DEF_MAX_PAYLOAD;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    FR_GOOD,
    FR_BAD_HDR,
    FR_BAD_SUM,
    FR_OVERSIZE,
    FR_TRUNC,
    FR_NOISE
  } frame_kind_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  header_length_sum_block_deframer u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Deframer state as the checker sees it.
  logic [7:0] hdr_first;
  logic [7:0] hdr_second;
  logic [9:0] min_bytes;
  phase_t prs_phase;
  logic [15:0] frm_len;
  logic [15:0] pay_cnt;
  logic [7:0] sum_acc;
  logic [7:0] pay_mem [MAX_PAY];
  logic frm_ok;
  logic [15:0] buf_bytes;

  in_item_t feed_q[$];
  out_item_t blocks_due[$];

  logic in_took = 1'b0;
  int src_wait = 0;
  int sink_wait = 0;
  int hold_left = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;

  int fail_cnt = 0;
  int rx_taken = 0;
  int blocks_seen = 0;
  int n_items = 0;
  int n_bufs = 0;
  int settings_cnt = 1;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] store_byte(input int pos);
    if (pos >= frm_len || pos >= MAX_PAY) return 8'h00;
    return pay_mem[pos];
  endfunction

  task automatic clear_parse();
    prs_phase = PH_HEAD1;
    frm_len = '0;
    pay_cnt = '0;
    sum_acc = '0;
    frm_ok = 1'b0;
    buf_bytes = '0;
  endtask

  task automatic take_rx(input in_item_t it);
    int nblk;
    int base;
    out_item_t blk;
    if (buf_bytes < 16'hFFFF) buf_bytes++;
    case (prs_phase)
      PH_HEAD1: prs_phase = (it.rx_byte == hdr_first) ? PH_HEAD2 : PH_SKIP;
      PH_HEAD2: prs_phase = (it.rx_byte == hdr_second) ? PH_LEN_LO : PH_SKIP;
      PH_LEN_LO: begin
        frm_len = {8'h00, it.rx_byte};
        prs_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frm_len[15:8] = it.rx_byte;
        pay_cnt = '0;
        sum_acc = '0;
        if (frm_len > MAX_PAY) prs_phase = PH_SKIP;
        else if (frm_len == 0) prs_phase = PH_CHECK;
        else prs_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pay_cnt < MAX_PAY) pay_mem[pay_cnt] = it.rx_byte;
        sum_acc = sum_acc + it.rx_byte;
        pay_cnt++;
        if (pay_cnt >= frm_len) prs_phase = PH_CHECK;
      end
      PH_CHECK: begin
        frm_ok = (it.rx_byte == sum_acc);
        prs_phase = PH_SKIP;
      end
      default: prs_phase = PH_SKIP;
    endcase
    if (it.buffer_end) begin
      if (frm_ok && buf_bytes >= min_bytes) begin
        nblk = frm_len / BLK_BYTES;
        if (nblk > MAX_BLK) nblk = MAX_BLK;
        for (int k = 0; k < nblk; k++) begin
          base = k * BLK_BYTES;
          blk.block_id = {store_byte(base + 1), store_byte(base)};
          for (int i = 0; i < 8; i++) blk.block_payload[8*i +: 8] = store_byte(base + 2 + i);
          blk.block_last = (k == nblk - 1);
          blocks_due = {blocks_due, blk};
        end
      end
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_first = 8'h00;
      hdr_second = 8'h00;
      min_bytes = MIN_BYTES_RESET;
      clear_parse();
      blocks_due.delete();
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_we) begin
        case (cfg_idx)
          REG_HDR_FIRST: hdr_first = cfg_wdata[7:0];
          REG_HDR_SECOND: hdr_second = cfg_wdata[7:0];
          REG_MIN_BYTES: min_bytes = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rx_taken++;
        take_rx(in_data);
      end
      if (out_valid && out_ready) begin
        blocks_seen++;
        if (blocks_due.size() == 0) begin
          $error("block transfer with none expected: id %h", out_data.block_id);
          fail_cnt++;
        end else begin
          out_item_t want;
          want = blocks_due.pop_front();
          if (out_data.block_id !== want.block_id) begin
            $error("block_id: expected %h, got %h", want.block_id, out_data.block_id);
            fail_cnt++;
          end
          if (out_data.block_payload !== want.block_payload) begin
            $error("block_payload: expected %h, got %h", want.block_payload,
                   out_data.block_payload);
            fail_cnt++;
          end
          if (out_data.block_last !== want.block_last) begin
            $error("block_last: expected %b, got %b", want.block_last, out_data.block_last);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_wait = 0;
    end else if (!in_valid || in_took) begin
      if (src_wait > 0) begin
        src_wait--;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        in_data <= feed_q.pop_front();
        in_valid <= 1'b1;
        src_wait = src_idle_en ? draw_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      sink_wait = snk_idle_en ? draw_gap() : 0;
    end
  end

  task automatic write_regs(input logic [7:0] h1, input logic [7:0] h2, input logic [9:0] mb);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_HDR_FIRST;
    cfg_wdata <= {2'b00, h1};
    @(negedge clk);
    cfg_idx <= REG_HDR_SECOND;
    cfg_wdata <= {2'b00, h2};
    @(negedge clk);
    cfg_idx <= REG_MIN_BYTES;
    cfg_wdata <= mb;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_cnt++;
  endtask

  task automatic push_frame(input frame_kind_t kind, input int len, input int tail);
    logic [7:0] bq[$];
    logic [7:0] sum;
    logic [7:0] b;
    int keep;
    in_item_t it;
    sum = 8'h00;
    if (kind == FR_NOISE) begin
      for (int i = 0; i <= len; i++) bq = {bq, 8'($urandom)};
    end else begin
      bq = {bq, hdr_first};
      bq = {bq, hdr_second};
      if (kind == FR_BAD_HDR) begin
        if ($urandom_range(0, 1)) bq[0] = hdr_first ^ 8'($urandom_range(1, 255));
        else bq[1] = hdr_second ^ 8'($urandom_range(1, 255));
      end
      if (kind == FR_OVERSIZE && len <= MAX_PAY) len = $urandom_range(MAX_PAY + 1, 65535);
      bq = {bq, len[7:0]};
      bq = {bq, len[15:8]};
      if (kind != FR_OVERSIZE) begin
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          sum = sum + b;
          bq = {bq, b};
        end
        bq = {bq, (kind == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum};
      end
      if (kind == FR_TRUNC) begin
        keep = $urandom_range(1, bq.size() - 1);
        while (bq.size() > keep) void'(bq.pop_back());
      end else begin
        for (int i = 0; i < tail; i++) bq = {bq, 8'($urandom)};
      end
    end
    foreach (bq[i]) begin
      it.rx_byte = bq[i];
      it.buffer_end = (i == bq.size() - 1);
      feed_q = {feed_q, it};
    end
    n_items += bq.size();
    n_bufs++;
  endtask

  task automatic wait_quiet();
    while (feed_q.size() != 0 || in_valid || blocks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame();
    int r;
    int len;
    int tail;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 99) < 3) ? $urandom_range(41, MAX_PAY) : $urandom_range(0, 40);
    tail = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 8);
    if (r < 65) push_frame(FR_GOOD, len, tail);
    else if (r < 73) push_frame(FR_BAD_HDR, len, tail);
    else if (r < 81) push_frame(FR_BAD_SUM, len, tail);
    else if (r < 89) push_frame(FR_TRUNC, len, tail);
    else if (r < 94) push_frame(FR_OVERSIZE, 0, tail);
    else push_frame(FR_NOISE, $urandom_range(0, 20), 0);
  endtask

  initial begin
    int phase;
    int base_items;
    int phase_start;
    int n0;
    int big_sz;
    int taken0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: a frame of exactly the minimum buffer length, and an empty payload.
    push_frame(FR_GOOD, 10, 0);
    push_frame(FR_GOOD, 0, 3);
    wait_quiet();

    write_regs(8'hFF, 8'h00, 10'd0);
    push_frame(FR_GOOD, 25, 2);
    push_frame(FR_BAD_HDR, 4, 0);
    push_frame(FR_BAD_SUM, 10, 0);
    push_frame(FR_OVERSIZE, MAX_PAY + 1, 1);
    push_frame(FR_OVERSIZE, 65535, 0);
    push_frame(FR_TRUNC, 12, 0);
    push_frame(FR_NOISE, 0, 0);
    push_frame(FR_GOOD, 9, 0);
    wait_quiet();

    // One byte short of the minimum, then exactly on it.
    write_regs(8'h00, 8'hFF, 10'd16);
    push_frame(FR_GOOD, 10, 0);
    push_frame(FR_GOOD, 10, 1);
    wait_quiet();

    write_regs(8'hA5, 8'h5A, 10'd645);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_UNUSED;
    cfg_wdata <= 10'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    push_frame(FR_GOOD, MAX_PAY, 0);
    push_frame(FR_GOOD, 20, 0);
    wait_quiet();

    base_items = n_items;
    phase = 0;
    while (n_items - base_items < 200) begin
      write_regs(8'($urandom), 8'($urandom),
                 ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 645))
                                             : 10'($urandom_range(0, 30)));
      src_idle_en = (phase != 1);
      snk_idle_en = (phase != 1);
      phase_start = n_items;
      while (n_items - phase_start < 100) random_frame();
      wait_quiet();
      phase++;
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    // Hold the receiver off once a long frame has gone in, while further frames are offered.
    write_regs(8'($urandom), 8'($urandom), 10'd0);
    taken0 = rx_taken;
    n0 = n_items;
    push_frame(FR_GOOD, 100, 0);
    big_sz = n_items - n0;
    push_frame(FR_GOOD, 20, 0);
    push_frame(FR_GOOD, 15, 2);
    push_frame(FR_GOOD, 30, 0);
    while (rx_taken < taken0 + big_sz) @(posedge clk);
    stall_reqs++;
    wait_quiet();

    $display("Run covered %0d byte transfers in %0d buffers over %0d register settings.",
             rx_taken, n_bufs, settings_cnt);
    $display("%0d blocks checked, including rejected, truncated and oversized frames.",
             blocks_seen);
    if (fail_cnt == 0) begin
      $display("PASS header_length_sum_block_deframer");
    end else begin
      $display("FAIL header_length_sum_block_deframer");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("FAIL header_length_sum_block_deframer");
    $finish;
  end

endmodule
